FILE: rtl/core/bsa_pkg.sv
// bsa_pkg: shared types and codes for the banker's safe allocator.
// No dependencies.
package bsa_pkg;
  localparam int Resources = 4;

  typedef enum logic [1:0] {
    OP_REQUEST = 2'd0,
    OP_RELEASE = 2'd1,
    OP_DECLARE = 2'd2,
    OP_LOAD    = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NEED      = 3'd1,
    ST_AVAIL     = 3'd2,
    ST_UNSAFE    = 3'd3,
    ST_REL_OVER  = 3'd4,
    ST_BAD_CUST  = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ,
    S_CHECK,
    S_APPLY,
    S_SCAN_INIT,
    S_SCAN_RD,
    S_SCAN_EVAL,
    S_SCAN_END,
    S_RESTORE,
    S_DONE
  } state_t;
endpackage

FILE: rtl/core/bsa_fit_unit.sv
// bsa_fit_unit: shared compare unit; checks four amounts against four limits.
// Depends on bsa_pkg.
module bsa_fit_unit
  import bsa_pkg::*;
#(
  parameter int W = 16
) (
  input  logic [Resources-1:0][W-1:0] lhs,
  input  logic [Resources-1:0][W-1:0] rhs,
  output logic                        fits
);
  always_comb begin
    fits = 1'b1;
    for (int r = 0; r < Resources; r++) begin
      if (lhs[r] > rhs[r]) fits = 1'b0;
    end
  end
endmodule

FILE: rtl/core/bankers_safe_allocator.sv
// bankers_safe_allocator: top level, sequencer and per-client count memories.
// Depends on bsa_pkg and bsa_fit_unit.
//
// Banker's algorithm allocator for four resource types and CUSTOMERS clients.
// One request is taken at a time; in_ready is low until its result has been
// handed off. Load, declare, release and a request that fails the need check
// pass through read, check and done; a request that passes the need check
// stays in check once more for the availability compare. A request that
// passes both checks runs a safety scan through one shared four-wide compare
// unit and the held/need memories, one client at a time (memory read, then
// compare and add). The scan restarts from client 0 after every pick and
// ends with one full pass that finds nothing, so it costs at most
// CUSTOMERS*(CUSTOMERS+3)/2 visits for a request.
// Amounts wider than COUNT_WIDTH saturate on load/declare and fail checks on
// request/release. All counts reset to zero; the memories are cleared by a
// per-client valid bit, so no clearing pass is needed.
module bankers_safe_allocator
  import bsa_pkg::*;
#(
  parameter int CUSTOMERS   = 8,
  parameter int COUNT_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  op,
  input  logic [2:0]  customer,
  input  logic [15:0] amount_0,
  input  logic [15:0] amount_1,
  input  logic [15:0] amount_2,
  input  logic [15:0] amount_3,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic        safe_checked
);
  localparam int CW  = COUNT_WIDTH;
  localparam int CIW = (CUSTOMERS > 1) ? $clog2(CUSTOMERS) : 1;
  localparam int AW  = 17; // amounts held one bit wider than any count compare needs
  localparam int XW  = (CW > 16) ? CW + 1 : AW;
  localparam logic [CW:0] CntMax = {1'b0, {CW{1'b1}}};

  typedef logic [Resources-1:0][CW-1:0] vec_t;
  typedef logic [Resources-1:0][XW-1:0] xvec_t;

  // client memories (one write, one read port each), valid bit per client
  vec_t mem_max  [CUSTOMERS];
  vec_t mem_held [CUSTOMERS];
  vec_t mem_need [CUSTOMERS];
  logic [CUSTOMERS-1:0] cvalid;
  vec_t rd_max, rd_held, rd_need;
  logic [CIW-1:0] rd_addr;

  state_t state, state_next;
  op_t             r_op;
  logic [2:0]      r_cust;
  logic [Resources-1:0][15:0] r_amt;
  vec_t            free_count, old_free, old_held, old_need, work;
  logic [CUSTOMERS-1:0] done;
  logic [CIW-1:0]  scan_idx;
  status_t         r_status;
  logic            r_checked;

  logic [CIW-1:0] cidx;
  assign cidx = CIW'(r_cust);
  logic cust_ok;
  assign cust_ok = ({29'd0, r_cust} < CUSTOMERS);

  // memory write port
  logic wr_en;
  logic [CIW-1:0] wr_addr;
  vec_t wr_max, wr_held, wr_need;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_max[wr_addr]  <= wr_max;
      mem_held[wr_addr] <= wr_held;
      mem_need[wr_addr] <= wr_need;
    end
    rd_max  <= cvalid[rd_addr] ? mem_max[rd_addr]  : '0;
    rd_held <= cvalid[rd_addr] ? mem_held[rd_addr] : '0;
    rd_need <= cvalid[rd_addr] ? mem_need[rd_addr] : '0;
  end

  // shared compare unit: operands muxed by state
  xvec_t cmp_l, cmp_r;
  logic  fits;
  bsa_fit_unit #(.W(XW)) u_fit (.lhs(cmp_l), .rhs(cmp_r), .fits(fits));

  logic check_need_ok;

  // request check uses two compares over two states; keep need result
  logic need_ok;

  always_comb begin
    for (int r = 0; r < Resources; r++) begin
      cmp_l[r] = XW'(r_amt[r]);
      cmp_r[r] = XW'(rd_need[r]);
      case (state)
        S_CHECK: begin
          if (r_op == OP_RELEASE) cmp_r[r] = XW'(rd_held[r]);
          else if (need_ok)       cmp_r[r] = XW'(free_count[r]);
        end
        S_SCAN_EVAL: begin
          cmp_l[r] = XW'(rd_need[r]);
          cmp_r[r] = XW'(work[r]);
        end
        default: ;
      endcase
    end
  end
  assign check_need_ok = fits;

  function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] a, input logic [XW-1:0] b);
    logic [XW:0] s;
    s = (XW+1)'(a) + (XW+1)'(b);
    return (s > (XW+1)'(CntMax)) ? CW'(CntMax) : s[CW-1:0];
  endfunction

  function automatic logic [CW-1:0] sat_amt(input logic [15:0] a);
    return ((XW)'(a) > XW'(CntMax)) ? CW'(CntMax) : CW'(a);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cvalid    <= '0;
      free_count<= '0;
      need_ok   <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: if (in_valid) begin
          r_op    <= op_t'(op);
          r_cust  <= customer;
          r_amt   <= {amount_3, amount_2, amount_1, amount_0};
          need_ok <= 1'b0;
        end
        S_CHECK: begin
          if (r_op == OP_REQUEST && !need_ok) need_ok <= check_need_ok;
          if (r_op == OP_LOAD) begin
            for (int r = 0; r < Resources; r++) free_count[r] <= sat_amt(r_amt[r]);
            r_status <= ST_OK; r_checked <= 1'b0;
          end else if (!cust_ok) begin
            r_status <= ST_BAD_CUST; r_checked <= 1'b0;
          end else if (r_op == OP_DECLARE) begin
            cvalid[cidx] <= 1'b1;
            r_status <= ST_OK; r_checked <= 1'b0;
          end else if (r_op == OP_RELEASE) begin
            r_checked <= 1'b0;
            r_status  <= fits ? ST_OK : ST_REL_OVER;
            if (fits) for (int r = 0; r < Resources; r++)
              free_count[r] <= sat_add(free_count[r], XW'(r_amt[r]));
          end else if (need_ok) begin
            r_status  <= fits ? ST_OK : ST_AVAIL;
            r_checked <= fits;
          end else if (!fits) begin
            r_status <= ST_NEED; r_checked <= 1'b0;
          end
        end
        S_APPLY: begin
          old_free <= free_count; old_held <= rd_held; old_need <= rd_need;
          for (int r = 0; r < Resources; r++)
            free_count[r] <= free_count[r] - CW'(r_amt[r]);
        end
        S_SCAN_INIT: begin
          work <= free_count; done <= '0; scan_idx <= '0;
        end
        S_SCAN_EVAL: begin
          if (!done[scan_idx] && fits) begin
            done[scan_idx] <= 1'b1;
            for (int r = 0; r < Resources; r++)
              work[r] <= sat_add(work[r], XW'(rd_held[r]));
            scan_idx <= '0;
          end else if ({1'b0, scan_idx} != (CIW+1)'(CUSTOMERS-1)) begin
            scan_idx <= scan_idx + 1'b1;
          end
        end
        S_SCAN_END: begin
          if (!(&done)) r_status <= ST_UNSAFE;
        end
        S_RESTORE: free_count <= old_free;
        default: ;
      endcase
    end
  end

  logic last_idx;
  assign last_idx = ({1'b0, scan_idx} == (CIW+1)'(CUSTOMERS-1));

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    rd_addr    = cidx;
    wr_en      = 1'b0;
    wr_addr    = cidx;
    wr_max     = rd_max;
    wr_held    = rd_held;
    wr_need    = rd_need;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        rd_addr  = CIW'(customer);
        if (in_valid) state_next = S_READ;
      end
      S_READ: state_next = S_CHECK;
      S_CHECK: begin
        if (r_op == OP_LOAD || !cust_ok) state_next = S_DONE;
        else if (r_op == OP_DECLARE) begin
          wr_en = 1'b1;
          for (int r = 0; r < Resources; r++) begin
            wr_max[r]  = sat_amt(r_amt[r]);
            wr_need[r] = sat_amt(r_amt[r]);
            wr_held[r] = '0;
          end
          state_next = S_DONE;
        end else if (r_op == OP_RELEASE) begin
          if (fits) begin
            wr_en = 1'b1;
            for (int r = 0; r < Resources; r++) begin
              wr_held[r] = rd_held[r] - CW'(r_amt[r]);
              wr_need[r] = (rd_max[r] > wr_held[r]) ? rd_max[r] - wr_held[r] : '0;
            end
          end
          state_next = S_DONE;
        end else if (need_ok) state_next = fits ? S_APPLY : S_DONE;
        else if (!fits) state_next = S_DONE;
      end
      S_APPLY: begin
        wr_en = 1'b1;
        for (int r = 0; r < Resources; r++) begin
          wr_held[r] = sat_add(rd_held[r], XW'(r_amt[r]));
          wr_need[r] = rd_need[r] - CW'(r_amt[r]);
        end
        state_next = S_SCAN_INIT;
      end
      S_SCAN_INIT: begin
        rd_addr = '0;
        state_next = S_SCAN_RD;
      end
      S_SCAN_RD: begin
        rd_addr = scan_idx;
        state_next = S_SCAN_EVAL;
      end
      S_SCAN_EVAL: begin
        if (!done[scan_idx] && fits) state_next = S_SCAN_RD;
        else if (last_idx) state_next = S_SCAN_END;
        else state_next = S_SCAN_RD;
      end
      S_SCAN_END: state_next = (&done) ? S_DONE : S_RESTORE;
      S_RESTORE: begin
        wr_en = 1'b1;
        wr_held = old_held;
        wr_need = old_need;
        state_next = S_DONE;
      end
      S_DONE: begin
        out_valid = 1'b1;
        rd_addr   = cidx;
        if (out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign status       = r_status;
  assign safe_checked = r_checked;

`ifndef SYNTH
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid)) else $error("ready while result pending");
  a_checked_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && safe_checked |-> (status == ST_OK || status == ST_UNSAFE))
    else $error("scan flag with wrong status");
  a_restore_unsafe: assert property (@(posedge clk) disable iff (rst)
    state == S_RESTORE |=> r_status == ST_UNSAFE) else $error("rollback without unsafe");
`endif
endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps
// tb: self-checking bench for bankers_safe_allocator (default parameters).
// Depends on bsa_pkg and the RTL; a scoreboard class predicts each response.
module tb;
  import bsa_pkg::*;

  localparam int NCUST = 8;
  localparam int CMAX = 16'hFFFF;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] op = OP_LOAD;
  logic [2:0] customer = '0;
  logic [15:0] amount_0 = '0, amount_1 = '0, amount_2 = '0, amount_3 = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [2:0] status;
  logic safe_checked;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  bankers_safe_allocator u_dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .op(op), .customer(customer), .amount_0(amount_0), .amount_1(amount_1),
    .amount_2(amount_2), .amount_3(amount_3), .out_valid(out_valid),
    .out_ready(out_ready), .status(status), .safe_checked(safe_checked)
  );

  typedef struct packed {
    status_t st;
    logic chk;
  } reply_t;

  // Allocator state mirror plus queue of pending replies.
  class alloc_board;
    int free_cnt[4];
    int max_c[NCUST][4];
    int held[NCUST][4];
    int need[NCUST][4];
    reply_t pending[$];
    int errors;
    int checked;
    int grants;
    int unsafe_cnt;

    function automatic int sat(int v);
      return (v > CMAX) ? CMAX : v;
    endfunction

    // Banker's safety scan over the current counts.
    function automatic bit is_safe();
      bit done[NCUST];
      int work[4];
      int pick;
      bit fits;
      foreach (work[r]) work[r] = free_cnt[r];
      foreach (done[c]) done[c] = 1'b0;
      forever begin
        pick = -1;
        for (int c = 0; c < NCUST && pick < 0; c++) begin
          if (!done[c]) begin
            fits = 1'b1;
            for (int r = 0; r < 4; r++) if (need[c][r] > work[r]) fits = 1'b0;
            if (fits) pick = c;
          end
        end
        if (pick < 0) break;
        done[pick] = 1'b1;
        for (int r = 0; r < 4; r++) work[r] = sat(work[r] + held[pick][r]);
      end
      foreach (done[c]) if (!done[c]) return 1'b0;
      return 1'b1;
    endfunction

    function void note_request(op_t o, int c, int a[4]);
      reply_t rp;
      int of[4], oh[4], on[4];
      rp.st = ST_OK;
      rp.chk = 1'b0;
      if (o == OP_LOAD) begin
        for (int r = 0; r < 4; r++) free_cnt[r] = a[r];
      end else if (c >= NCUST) begin
        rp.st = ST_BAD_CUST;
      end else if (o == OP_DECLARE) begin
        for (int r = 0; r < 4; r++) begin
          max_c[c][r] = a[r];
          held[c][r] = 0;
          need[c][r] = a[r];
        end
      end else if (o == OP_RELEASE) begin
        for (int r = 0; r < 4; r++) if (a[r] > held[c][r]) rp.st = ST_REL_OVER;
        if (rp.st == ST_OK)
          for (int r = 0; r < 4; r++) begin
            free_cnt[r] = sat(free_cnt[r] + a[r]);
            held[c][r] -= a[r];
            need[c][r] = (max_c[c][r] > held[c][r]) ? max_c[c][r] - held[c][r] : 0;
          end
      end else begin
        for (int r = 0; r < 4; r++) if (a[r] > need[c][r]) rp.st = ST_NEED;
        if (rp.st == ST_OK)
          for (int r = 0; r < 4; r++) if (a[r] > free_cnt[r]) rp.st = ST_AVAIL;
        if (rp.st == ST_OK) begin
          for (int r = 0; r < 4; r++) begin
            of[r] = free_cnt[r];
            oh[r] = held[c][r];
            on[r] = need[c][r];
            free_cnt[r] -= a[r];
            held[c][r] = sat(held[c][r] + a[r]);
            need[c][r] -= a[r];
          end
          rp.chk = 1'b1;
          if (!is_safe()) begin
            rp.st = ST_UNSAFE;
            unsafe_cnt++;
            for (int r = 0; r < 4; r++) begin
              free_cnt[r] = of[r];
              held[c][r] = oh[r];
              need[c][r] = on[r];
            end
          end else begin
            grants++;
          end
        end
      end
      pending.push_back(rp);
    endfunction

    function void check_reply(logic [2:0] st, logic chk);
      reply_t ex;
      checked++;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected response: status=%0d checked=%0b", st, chk);
        return;
      end
      ex = pending.pop_front();
      if (st !== ex.st || chk !== ex.chk) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected status=%0d checked=%0b, got status=%0d checked=%0b",
                   ex.st, ex.chk, st, chk);
      end
    endfunction
  endclass

  alloc_board board = new();
  int gap_left = 0;
  int burst_left = 0;

  // Sender: one request at a time, random bursts and gaps before each.
  task automatic send_request(op_t o, int c, int a0, int a1, int a2, int a3);
    int amt[4];
    if (burst_left == 0) begin
      gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
      burst_left = $urandom_range(1, 16);
    end
    repeat (gap_left) @(negedge clk);
    gap_left = 0;
    burst_left--;
    @(negedge clk);
    op <= o;
    customer <= c[2:0];
    amount_0 <= a0[15:0];
    amount_1 <= a1[15:0];
    amount_2 <= a2[15:0];
    amount_3 <= a3[15:0];
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    amt = '{a0, a1, a2, a3};
    board.note_request(o, c, amt);
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Receiver: stall pattern drifts between busy, sparse and always-ready.
  always @(negedge clk) begin
    if (rst) out_ready <= 1'b0;
    else case (($time / 4000) % 3)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      default: out_ready <= ($urandom_range(0, 4) == 0);
    endcase
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) board.check_reply(status, safe_checked);
  end

  function automatic int rnd_amt(int hi);
    return $urandom_range(0, hi);
  endfunction

  initial begin
    int c;
    int o;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: empty system, extremes, status codes other than ST_AVAIL and ST_BAD_CUST.
    send_request(OP_REQUEST, 0, 0, 0, 0, 0);             // zero request on empty state
    send_request(OP_REQUEST, 1, 1, 0, 0, 0);             // exceeds need
    send_request(OP_LOAD, 7, CMAX, CMAX, CMAX, CMAX);
    send_request(OP_DECLARE, 0, CMAX, CMAX, CMAX, CMAX);
    send_request(OP_REQUEST, 0, CMAX, CMAX, CMAX, CMAX); // grab everything, safe
    send_request(OP_RELEASE, 0, CMAX, 0, 0, 0);
    send_request(OP_RELEASE, 0, 1, 0, 0, 0);             // release exceeds allocation
    send_request(OP_RELEASE, 0, 0, CMAX, CMAX, CMAX);
    send_request(OP_LOAD, 0, 10, 10, 10, 10);
    send_request(OP_DECLARE, 1, 8, 8, 8, 8);
    send_request(OP_DECLARE, 2, 8, 8, 8, 8);
    send_request(OP_REQUEST, 1, 4, 4, 4, 4);
    send_request(OP_REQUEST, 2, 4, 4, 4, 4);             // unsafe, rolled back
    send_request(OP_REQUEST, 2, 9, 0, 0, 0);             // exceeds need
    send_request(OP_REQUEST, 1, 4, 4, 4, 4);             // unsafe, rolled back
    send_request(OP_REQUEST, 2, 2, 2, 2, 2);
    send_request(OP_RELEASE, 1, 4, 4, 4, 4);
    send_request(OP_DECLARE, 2, 1, 1, 1, 1);             // drops held, not returned
    send_request(OP_LOAD, 0, CMAX, CMAX, CMAX, CMAX);
    send_request(OP_RELEASE, 1, 0, 0, 0, 0);             // zero release with free counts at maximum
    send_request(OP_DECLARE, 3, 0, 0, 0, 0);

    // Random: mostly small, well-formed traffic so scans are exercised.
    for (int i = 0; i < 900; i++) begin
      c = $urandom_range(0, NCUST - 1);
      o = $urandom_range(0, 99);
      if (o < 4)
        send_request(OP_LOAD, c, rnd_amt(40), rnd_amt(40), rnd_amt(40), rnd_amt(40));
      else if (o < 6)
        send_request(OP_LOAD, c, rnd_amt(CMAX), rnd_amt(CMAX), rnd_amt(CMAX),
                     rnd_amt(CMAX));
      else if (o < 18)
        send_request(OP_DECLARE, c, rnd_amt(20), rnd_amt(20), rnd_amt(20), rnd_amt(20));
      else if (o < 20)
        send_request(OP_DECLARE, c, rnd_amt(CMAX), rnd_amt(CMAX), rnd_amt(CMAX),
                     rnd_amt(CMAX));
      else if (o < 40)
        send_request(OP_RELEASE, c, rnd_amt(board.held[c][0]), rnd_amt(board.held[c][1]),
                     rnd_amt(board.held[c][2]), rnd_amt(board.held[c][3]));
      else if (o < 44)
        send_request(OP_RELEASE, c, rnd_amt(CMAX), rnd_amt(CMAX), rnd_amt(CMAX),
                     rnd_amt(CMAX));
      else if (o < 90)
        send_request(OP_REQUEST, c, rnd_amt(board.need[c][0]), rnd_amt(board.need[c][1]),
                     rnd_amt(board.need[c][2]), rnd_amt(board.need[c][3]));
      else
        send_request(OP_REQUEST, c, rnd_amt(CMAX), rnd_amt(CMAX), rnd_amt(CMAX),
                     rnd_amt(CMAX));
    end

    while (board.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("covered %0d responses: %0d safe grants, %0d unsafe rollbacks",
             board.checked, board.grants, board.unsafe_cnt);
    if (board.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("mismatches: %0d", board.errors);
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout");
    $display("status: fail");
    $finish;
  end
endmodule

FILE: sim.f
rtl/core/bsa_pkg.sv
rtl/core/bsa_fit_unit.sv
rtl/core/bankers_safe_allocator.sv
bench/tb.sv
